// ===== rtl/mdb_pkg.sv =====
// ----------------------------------------------------------------------------
// mdb_pkg
// Shared types and constants for the cashless reader command handler.
// ----------------------------------------------------------------------------
package mdb_pkg;

   localparam logic [1:0] OP_WORD  = 2'd0;
   localparam logic [1:0] OP_TICK  = 2'd1;
   localparam logic [1:0] OP_EVENT = 2'd2;

   localparam logic [1:0] CSR_FUNDS = 2'd0;
   localparam logic [1:0] CSR_IDLE  = 2'd1;
   localparam logic [1:0] CSR_VEND  = 2'd2;

   localparam logic [7:0] READER_ADDR = 8'h10;

   // reply kinds queued from front to back
   localparam logic [2:0] RK_ONE   = 3'd0;  // single byte
   localparam logic [2:0] RK_THREE = 3'd1;  // code then 16-bit amount
   localparam logic [2:0] RK_SETUP = 3'd2;  // setup config reply
   localparam logic [2:0] RK_ID    = 3'd3;  // expansion id reply

   typedef struct packed {
      logic [1:0]  operation;
      logic [8:0]  bus_word;
      logic [2:0]  event_code;
      logic [15:0] event_amount;
   } req_type;

   typedef struct packed {
      logic [8:0] tx_word;
      logic       last_word;
   } rsp_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [7:0]  code;
      logic [15:0] amount;
   } job_type;

   function automatic logic [7:0] setup_byte(input logic [2:0] i);
      logic [7:0] b;
      unique case (i)
         3'd0: b = 8'h01;
         3'd1: b = 8'h01;
         3'd2: b = 8'hff;
         3'd3: b = 8'hff;
         3'd4: b = 8'h01;
         3'd5: b = 8'h02;
         3'd6: b = 8'd120;
         default: b = 8'h09;
      endcase
      return b;
   endfunction

endpackage

// ===== rtl/mdb_front.sv =====
// ----------------------------------------------------------------------------
// mdb_front
// Frames bus words, decodes reader commands, keeps state and emits reply jobs.
// ----------------------------------------------------------------------------
module mdb_front #(
   parameter int BUFFER_DEPTH = 36
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  mdb_pkg::req_type     in_data,
   input  logic [15:0]          funds,
   input  logic [19:0]          idle_to,
   input  logic [19:0]          vend_to,
   output logic                 job_valid,
   output mdb_pkg::job_type     job
);
   localparam int CW = $clog2(BUFFER_DEPTH + 1);

   typedef enum logic [2:0] {
      ST_INACTIVE, ST_DISABLED, ST_ENABLED, ST_IDLE, ST_VEND
   } rstate_type;

   rstate_type  state_ff, state_in;
   logic [6:0]  pend_ff, pend_in;
   logic [15:0] amt_ff, amt_in;
   logic        frame_ff, frame_in;
   logic [7:0]  sum_ff, sum_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [8:0]  cmd_ff, cmd_in;
   logic [7:0]  sub_ff, sub_in;
   logic [31:0] now_ff, now_in;
   logic [31:0] mark_ff, mark_in;
   logic        jv_in;
   mdb_pkg::job_type job_in;

   logic [7:0]  lo;
   logic [31:0] elapsed;

   always_comb begin
      state_in = state_ff; pend_in = pend_ff; amt_in = amt_ff;
      frame_in = frame_ff; sum_in = sum_ff; cnt_in = cnt_ff;
      cmd_in = cmd_ff; sub_in = sub_ff; now_in = now_ff; mark_in = mark_ff;
      jv_in = 1'b0;
      job_in = '0;
      lo = in_data.bus_word[7:0];
      elapsed = now_ff - mark_ff;
      if (in_valid) begin
         unique case (in_data.operation)
            mdb_pkg::OP_TICK: now_in = now_ff + 32'd1;
            mdb_pkg::OP_EVENT: begin
               unique case (in_data.event_code)
                  3'd0: pend_in[5] = 1'b1;
                  3'd1: begin pend_in[2] = 1'b1; amt_in = in_data.event_amount; end
                  3'd2: pend_in[3] = 1'b1;
                  3'd3: pend_in[4] = 1'b1;
                  3'd4: pend_in[6] = 1'b1;
                  3'd5: pend_in[0] = 1'b1;
                  default: ;
               endcase
            end
            mdb_pkg::OP_WORD: begin
               logic [8:0] c;
               logic [7:0] s;
               logic [7:0] sm;
               logic       f;
               logic [CW-1:0] n;
               c = cmd_ff; s = sub_ff; sm = sum_ff; f = frame_ff; n = cnt_ff;
               if (in_data.bus_word[8]) begin
                  f = 1'b1; sm = 8'd0; n = '0;
               end
               if (f) begin
                  if (n < CW'(BUFFER_DEPTH)) begin
                     if (n == '0) c = in_data.bus_word;
                     else if (n == CW'(1)) s = lo;
                     n = n + CW'(1);
                  end
                  cmd_in = c; sub_in = s; cnt_in = n;
                  if (sm == lo) begin
                     frame_in = 1'b0;
                     sum_in = sm;
                     if (c[7:3] == mdb_pkg::READER_ADDR[7:3]) begin
                        unique case (c[2:0])
                           3'd0: begin state_in = ST_INACTIVE; pend_in[1] = 1'b1; end
                           3'd1: if (s == 8'h00) begin
                              state_in = ST_DISABLED; jv_in = 1'b1;
                              job_in.kind = mdb_pkg::RK_SETUP;
                           end
                           3'd2: begin
                              job_in.kind = mdb_pkg::RK_ONE;
                              priority if (pend_ff[0]) begin
                                 pend_in[0] = 1'b0; jv_in = 1'b1; job_in.code = 8'h0b;
                              end else if (pend_ff[1]) begin
                                 pend_in[1] = 1'b0; jv_in = 1'b1; job_in.code = 8'h00;
                              end else if (pend_ff[2]) begin
                                 pend_in[2] = 1'b0; jv_in = 1'b1; job_in.code = 8'h05;
                                 job_in.kind = mdb_pkg::RK_THREE; job_in.amount = amt_ff;
                              end else if (pend_ff[3]) begin
                                 pend_in[3] = 1'b0; jv_in = 1'b1; job_in.code = 8'h06;
                                 state_in = ST_IDLE;
                              end else if (pend_ff[4]) begin
                                 pend_in[4] = 1'b0; jv_in = 1'b1; job_in.code = 8'h07;
                                 state_in = ST_ENABLED;
                              end else if (pend_ff[5]) begin
                                 pend_in[5] = 1'b0; pend_in[2] = 1'b0; jv_in = 1'b1;
                                 state_in = ST_IDLE; mark_in = now_ff;
                                 job_in.code = 8'h03;
                                 job_in.kind = mdb_pkg::RK_THREE; job_in.amount = funds;
                              end else if (pend_ff[6]) begin
                                 pend_in[6] = 1'b0; jv_in = 1'b1; job_in.code = 8'h04;
                              end else begin
                                 if (state_ff == ST_IDLE && elapsed > {12'd0, idle_to})
                                    pend_in[6] = 1'b1;
                                 if (state_ff == ST_VEND && elapsed > {12'd0, vend_to})
                                    pend_in[3] = 1'b1;
                              end
                           end
                           3'd3: begin
                              if (s == 8'h00) begin
                                 state_in = ST_VEND; mark_in = now_ff;
                              end else if (s == 8'h01) pend_in[3] = 1'b1;
                              else if (s == 8'h02 || s == 8'h03) begin
                                 state_in = ST_IDLE;
                                 mark_in = now_ff - {12'd0, idle_to} + 32'd1000;
                              end else if (s == 8'h04) pend_in[4] = 1'b1;
                           end
                           3'd4: begin
                              if (s == 8'h00) state_in = ST_DISABLED;
                              else if (s == 8'h01) state_in = ST_ENABLED;
                              else if (s == 8'h02) begin
                                 jv_in = 1'b1; job_in.kind = mdb_pkg::RK_ONE;
                                 job_in.code = 8'h08;
                              end
                           end
                           3'd7: if (s == 8'h00) begin
                              jv_in = 1'b1; job_in.kind = mdb_pkg::RK_ID;
                           end
                           default: ;
                        endcase
                     end
                  end else begin
                     frame_in = 1'b1;
                     sum_in = sm + lo;
                  end
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INACTIVE; pend_ff <= '0; amt_ff <= '0; frame_ff <= 1'b0;
         sum_ff <= '0; cnt_ff <= '0; now_ff <= '0; mark_ff <= '0; job_valid <= 1'b0;
      end else begin
         state_ff <= state_in; pend_ff <= pend_in; amt_ff <= amt_in;
         frame_ff <= frame_in; sum_ff <= sum_in; cnt_ff <= cnt_in;
         now_ff <= now_in; mark_ff <= mark_in; job_valid <= jv_in;
      end
      cmd_ff <= cmd_in;
      sub_ff <= sub_in;
      job <= job_in;
   end
endmodule

// ===== rtl/mdb_jobq.sv =====
// ----------------------------------------------------------------------------
// mdb_jobq
// Small register queue of reply jobs between decode and transmit.
// ----------------------------------------------------------------------------
module mdb_jobq (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  mdb_pkg::job_type  push_data,
   output logic              almost_full,
   input  logic              pop,
   output logic              empty,
   output mdb_pkg::job_type  head
);
   mdb_pkg::job_type mem_ff [4];
   logic [1:0] wp_ff, rp_ff;
   logic [2:0] cnt_ff;

   assign empty = (cnt_ff == 3'd0);
   assign almost_full = (cnt_ff >= 3'd2);
   assign head = mem_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0; rp_ff <= '0; cnt_ff <= '0;
      end else begin
         if (push) wp_ff <= wp_ff + 2'd1;
         if (pop) rp_ff <= rp_ff + 2'd1;
         cnt_ff <= cnt_ff + {2'd0, push} - {2'd0, pop};
      end
      if (push) mem_ff[wp_ff] <= push_data;
   end
endmodule

// ===== rtl/mdb_back.sv =====
// ----------------------------------------------------------------------------
// mdb_back
// Expands reply jobs into data words and a closing checksum word.
// ----------------------------------------------------------------------------
module mdb_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              job_empty,
   input  mdb_pkg::job_type  job,
   output logic              job_pop,
   output logic              rsp_empty,
   output mdb_pkg::rsp_type  rsp_data,
   input  logic              rsp_pop
);
   logic [4:0] idx_ff;
   logic [7:0] sum_ff;
   logic       ov_ff;
   mdb_pkg::rsp_type out_ff;
   logic [4:0] len;
   logic [7:0] b;
   logic       room;

   always_comb begin
      unique case (job.kind)
         mdb_pkg::RK_THREE: len = 5'd3;
         mdb_pkg::RK_SETUP: len = 5'd8;
         mdb_pkg::RK_ID:    len = 5'd30;
         default:           len = 5'd1;
      endcase
      unique case (job.kind)
         mdb_pkg::RK_THREE: b = (idx_ff == 5'd0) ? job.code :
                               (idx_ff == 5'd1) ? job.amount[15:8] : job.amount[7:0];
         mdb_pkg::RK_SETUP: b = mdb_pkg::setup_byte(idx_ff[2:0]);
         mdb_pkg::RK_ID:    b = (idx_ff == 5'd0) ? 8'h09 : 8'h20;
         default:           b = job.code;
      endcase
   end

   assign room = !ov_ff || rsp_pop;
   assign rsp_empty = !ov_ff;
   assign rsp_data = out_ff;
   assign job_pop = room && !job_empty && (idx_ff == len);

   always_ff @(posedge clock) begin
      if (reset) begin
         ov_ff <= 1'b0; idx_ff <= '0; sum_ff <= '0;
      end else begin
         if (rsp_pop) ov_ff <= 1'b0;
         if (room && !job_empty) begin
            ov_ff <= 1'b1;
            if (idx_ff == len) begin
               out_ff <= '{tx_word: {1'b1, sum_ff}, last_word: 1'b1};
               idx_ff <= '0; sum_ff <= '0;
            end else begin
               out_ff <= '{tx_word: {1'b0, b}, last_word: 1'b0};
               idx_ff <= idx_ff + 5'd1; sum_ff <= sum_ff + b;
            end
         end
      end
   end
endmodule

// ===== rtl/mdb_cashless_reader_handler.sv =====
// ----------------------------------------------------------------------------
// mdb_cashless_reader_handler
// Cashless reader command handler: framing, decode, reply generation.
// ----------------------------------------------------------------------------
// one item taken per cycle unless full; decode registers jobs before the job queue
// first reply word reaches the ports via decode register, job queue, output register
// replies drain one word per cycle while pop is held, n data words plus one checksum word
// full holds while the job queue nears capacity; synchronous reset restores
// register defaults, inactive reader state and empty queues
module mdb_cashless_reader_handler #(
   parameter int BUFFER_DEPTH = 36
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             full,
   input  mdb_pkg::req_type req_data,
   output logic             empty,
   input  logic             pop,
   output mdb_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [1:0]       csr_index,
   input  logic [19:0]      csr_data
);
   logic [15:0] funds_ff;
   logic [19:0] idle_ff, vend_ff;
   logic jv, af, jq_empty, jq_pop;
   mdb_pkg::job_type job, head;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         funds_ff <= '0; idle_ff <= 20'd45000; vend_ff <= 20'd90000;
      end else if (csr_valid) begin
         unique case (csr_index)
            mdb_pkg::CSR_FUNDS: funds_ff <= csr_data[15:0];
            mdb_pkg::CSR_IDLE:  idle_ff <= csr_data;
            mdb_pkg::CSR_VEND:  vend_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // frontend can have one job in flight beyond queue count
   assign full = af;

   mdb_front #(.BUFFER_DEPTH(BUFFER_DEPTH)) u_front (
      .clock, .reset, .in_valid(push && !full), .in_data(req_data),
      .funds(funds_ff), .idle_to(idle_ff), .vend_to(vend_ff),
      .job_valid(jv), .job
   );

   mdb_jobq u_jobq (
      .clock, .reset, .push(jv), .push_data(job), .almost_full(af),
      .pop(jq_pop), .empty(jq_empty), .head
   );

   mdb_back u_back (
      .clock, .reset, .job_empty(jq_empty), .job(head), .job_pop(jq_pop),
      .rsp_empty(empty), .rsp_data, .rsp_pop(pop)
   );
endmodule

// ===== tb/sv/mdb_reader_tb_pkg.sv =====
// ----------------------------------------------------------------------------
// mdb_reader_tb_pkg
// Command, host event and reader state codes shared by the testbench files.
// ----------------------------------------------------------------------------
package mdb_reader_tb_pkg;

   // low three bits of the command word
   localparam logic [2:0] CMD_RESET     = 3'd0;
   localparam logic [2:0] CMD_SETUP     = 3'd1;
   localparam logic [2:0] CMD_POLL      = 3'd2;
   localparam logic [2:0] CMD_VEND      = 3'd3;
   localparam logic [2:0] CMD_READER    = 3'd4;
   localparam logic [2:0] CMD_EXPANSION = 3'd7;

   // host event codes
   localparam logic [2:0] HEV_BEGIN   = 3'd0;
   localparam logic [2:0] HEV_APPROVE = 3'd1;
   localparam logic [2:0] HEV_DENY    = 3'd2;
   localparam logic [2:0] HEV_END     = 3'd3;
   localparam logic [2:0] HEV_CANCEL  = 3'd4;
   localparam logic [2:0] HEV_OUTSEQ  = 3'd5;

   typedef enum logic [2:0] {
      RD_INACTIVE = 3'd0,
      RD_DISABLED = 3'd1,
      RD_ENABLED  = 3'd2,
      RD_IDLE     = 3'd3,
      RD_VEND     = 3'd4
   } reader_state_t;

   // pending event bits
   localparam int PE_OUTSEQ   = 0;
   localparam int PE_JUSTRST  = 1;
   localparam int PE_APPROVED = 2;
   localparam int PE_DENIED   = 3;
   localparam int PE_END      = 4;
   localparam int PE_BEGIN    = 5;
   localparam int PE_CANCEL   = 6;

endpackage

// ===== tb/sv/mdb_reader_checker.sv =====
// ----------------------------------------------------------------------------
// mdb_reader_checker
// Watches the request, reply and register channels, predicts every reply
// word of the reader handler and compares it with what comes out.
// ----------------------------------------------------------------------------
module mdb_reader_checker #(
   parameter int BUFFER_DEPTH = 36
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic             full,
   input  mdb_pkg::req_type req_data,
   input  logic             empty,
   input  logic             pop,
   input  mdb_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   input  logic             csr_ready,
   input  logic [1:0]       csr_index,
   input  logic [19:0]      csr_data,
   output int               errors,
   output int               words_due,
   output int               words_seen
);
   import mdb_pkg::*;
   import mdb_reader_tb_pkg::*;

   logic [15:0]   funds;
   logic [19:0]   idle_limit;
   logic [19:0]   vend_limit;
   reader_state_t rstate;
   logic [6:0]    pend;
   logic [15:0]   approved;
   logic          framing;
   logic [7:0]    rsum;
   int            nwords;
   logic [8:0]    cmd_word;
   logic [7:0]    sub_byte;
   logic [31:0]   now;
   logic [31:0]   mark;

   logic [7:0]    reply_bytes[$];
   rsp_type       reply_due[$];

   assign words_due = reply_due.size();

   function automatic void add_byte(logic [7:0] b);
      if (reply_bytes.size() < 30) reply_bytes.push_back(b);
   endfunction

   function automatic void answer_poll();
      logic [31:0] elapsed;
      if (pend[PE_OUTSEQ]) begin
         pend[PE_OUTSEQ] = 1'b0;
         add_byte(8'h0b);
      end else if (pend[PE_JUSTRST]) begin
         pend[PE_JUSTRST] = 1'b0;
         add_byte(8'h00);
      end else if (pend[PE_APPROVED]) begin
         pend[PE_APPROVED] = 1'b0;
         add_byte(8'h05);
         add_byte(approved[15:8]);
         add_byte(approved[7:0]);
      end else if (pend[PE_DENIED]) begin
         pend[PE_DENIED] = 1'b0;
         add_byte(8'h06);
         rstate = RD_IDLE;
      end else if (pend[PE_END]) begin
         pend[PE_END] = 1'b0;
         add_byte(8'h07);
         rstate = RD_ENABLED;
      end else if (pend[PE_BEGIN]) begin
         pend[PE_BEGIN] = 1'b0;
         pend[PE_APPROVED] = 1'b0;
         rstate = RD_IDLE;
         mark = now;
         add_byte(8'h03);
         add_byte(funds[15:8]);
         add_byte(funds[7:0]);
      end else if (pend[PE_CANCEL]) begin
         pend[PE_CANCEL] = 1'b0;
         add_byte(8'h04);
      end else begin
         elapsed = now - mark;
         if (rstate == RD_IDLE && elapsed > {12'd0, idle_limit}) pend[PE_CANCEL] = 1'b1;
         if (rstate == RD_VEND && elapsed > {12'd0, vend_limit}) pend[PE_DENIED] = 1'b1;
      end
   endfunction

   function automatic void decode_frame();
      if (cmd_word[7:3] != READER_ADDR[7:3] || cmd_word[8] != 1'b1) return;
      case (cmd_word[2:0])
         CMD_RESET: begin
            rstate = RD_INACTIVE;
            pend[PE_JUSTRST] = 1'b1;
         end
         CMD_SETUP: begin
            if (sub_byte == 8'h00) begin
               rstate = RD_DISABLED;
               add_byte(8'h01); add_byte(8'h01); add_byte(8'hff); add_byte(8'hff);
               add_byte(8'h01); add_byte(8'h02); add_byte(8'd120); add_byte(8'h09);
            end
         end
         CMD_POLL: answer_poll();
         CMD_VEND: begin
            if (sub_byte == 8'h00) begin
               rstate = RD_VEND;
               mark = now;
            end else if (sub_byte == 8'h01) begin
               pend[PE_DENIED] = 1'b1;
            end else if (sub_byte == 8'h02 || sub_byte == 8'h03) begin
               rstate = RD_IDLE;
               mark = now - {12'd0, idle_limit} + 32'd1000;
            end else if (sub_byte == 8'h04) begin
               pend[PE_END] = 1'b1;
            end
         end
         CMD_READER: begin
            if (sub_byte == 8'h00) rstate = RD_DISABLED;
            else if (sub_byte == 8'h01) rstate = RD_ENABLED;
            else if (sub_byte == 8'h02) add_byte(8'h08);
         end
         CMD_EXPANSION: begin
            if (sub_byte == 8'h00) begin
               add_byte(8'h09);
               for (int i = 1; i < 30; i++) add_byte(8'h20);
            end
         end
         default: ;
      endcase
   endfunction

   function automatic void take_word(logic [8:0] w);
      if (w[8]) begin
         framing = 1'b1;
         rsum = 8'd0;
         nwords = 0;
      end
      if (!framing) return;
      if (nwords < BUFFER_DEPTH) begin
         if (nwords == 0) cmd_word = w;
         else if (nwords == 1) sub_byte = w[7:0];
         nwords++;
      end
      if (rsum == w[7:0]) begin
         framing = 1'b0;
         decode_frame();
      end else begin
         rsum = rsum + w[7:0];
      end
   endfunction

   function automatic void predict_item(req_type it);
      logic [7:0] sum;
      rsp_type    r;
      reply_bytes.delete();
      case (it.operation)
         OP_WORD: take_word(it.bus_word);
         OP_TICK: now = now + 32'd1;
         OP_EVENT: begin
            case (it.event_code)
               HEV_BEGIN:   pend[PE_BEGIN] = 1'b1;
               HEV_APPROVE: begin
                  pend[PE_APPROVED] = 1'b1;
                  approved = it.event_amount;
               end
               HEV_DENY:    pend[PE_DENIED] = 1'b1;
               HEV_END:     pend[PE_END] = 1'b1;
               HEV_CANCEL:  pend[PE_CANCEL] = 1'b1;
               HEV_OUTSEQ:  pend[PE_OUTSEQ] = 1'b1;
               default: ;
            endcase
         end
         default: ;
      endcase
      if (reply_bytes.size() == 0) return;
      sum = 8'd0;
      foreach (reply_bytes[k]) begin
         sum = sum + reply_bytes[k];
         r.tx_word = {1'b0, reply_bytes[k]};
         r.last_word = 1'b0;
         reply_due.push_back(r);
      end
      r.tx_word = {1'b1, sum};
      r.last_word = 1'b1;
      reply_due.push_back(r);
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         funds = 16'd0;
         idle_limit = 20'd45000;
         vend_limit = 20'd90000;
         rstate = RD_INACTIVE;
         pend = '0;
         approved = '0;
         framing = 1'b0;
         rsum = '0;
         nwords = 0;
         cmd_word = '0;
         sub_byte = '0;
         now = '0;
         mark = '0;
         reply_due.delete();
         errors <= 0;
         words_seen <= 0;
      end else begin
         // reply side first: a beat accepted now was predicted earlier
         if (pop && !empty) begin
            words_seen <= words_seen + 1;
            if (reply_due.size() == 0) begin
               $error("reply beat with nothing expected: tx_word=%h last_word=%b",
                      rsp_data.tx_word, rsp_data.last_word);
               errors <= errors + 1;
            end else begin
               want = reply_due.pop_front();
               if (rsp_data.tx_word !== want.tx_word) begin
                  $error("tx_word: expected %h, got %h", want.tx_word, rsp_data.tx_word);
                  errors <= errors + 1;
               end else if (rsp_data.last_word !== want.last_word) begin
                  $error("last_word: expected %b, got %b", want.last_word,
                         rsp_data.last_word);
                  errors <= errors + 1;
               end
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_FUNDS: funds = csr_data[15:0];
               CSR_IDLE:  idle_limit = csr_data;
               CSR_VEND:  vend_limit = csr_data;
               default: ;
            endcase
         end
         if (push && !full) predict_item(req_data);
      end
   end

endmodule

// ===== tb/sv/mdb_cashless_reader_handler_tb.sv =====
// ----------------------------------------------------------------------------
// mdb_cashless_reader_handler_tb
// Drives bus frames, ticks and host events into the reader handler across
// several register settings; a checker beside the block scores every reply.
// ----------------------------------------------------------------------------
module mdb_cashless_reader_handler_tb;
   import mdb_pkg::*;
   import mdb_reader_tb_pkg::*;

   localparam int LIMIT = 400000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        push = 1'b0;
   logic        full;
   req_type     req_data = '0;
   logic        empty;
   logic        pop = 1'b0;
   rsp_type     rsp_data;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic [19:0] csr_data = '0;

   int errors, words_due, words_seen;
   int cycles = 0;
   int items = 0;
   int frames = 0;
   int csr_writes = 0;
   bit calm = 1'b0;

   always #6 clock = ~clock;

   mdb_cashless_reader_handler dut (
      .clock, .reset, .push, .full, .req_data, .empty, .pop, .rsp_data,
      .csr_valid, .csr_ready, .csr_index, .csr_data
   );

   mdb_reader_checker chk (
      .clock, .reset, .push, .full, .req_data, .empty, .pop, .rsp_data,
      .csr_valid, .csr_ready, .csr_index, .csr_data,
      .errors, .words_due, .words_seen
   );

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // reply side stalls about a quarter of the time unless in a calm stretch
   always @(posedge clock) pop <= calm || ($urandom_range(0, 99) >= 24);

   task automatic put_item(req_type it);
      if (!calm && $urandom_range(0, 99) < 24) begin
         push <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      push <= 1'b1;
      req_data <= it;
      do @(posedge clock); while (full);
      items++;
   endtask

   task automatic stop_push();
      push <= 1'b0;
      @(posedge clock);
   endtask

   task automatic put_word(logic [8:0] w);
      req_type it;
      it = '0;
      it.operation = OP_WORD;
      it.bus_word = w;
      it.event_code = 3'($urandom);
      it.event_amount = 16'($urandom);
      put_item(it);
   endtask

   task automatic put_ticks(int n);
      req_type it;
      for (int i = 0; i < n; i++) begin
         it = 30'($urandom);
         it.operation = OP_TICK;
         put_item(it);
      end
   endtask

   task automatic put_event(logic [2:0] code, logic [15:0] amount);
      req_type it;
      it = '0;
      it.operation = OP_EVENT;
      it.bus_word = 9'($urandom);
      it.event_code = code;
      it.event_amount = amount;
      put_item(it);
   endtask

   // address word, subcommand, filler bytes that never close early, checksum
   task automatic put_frame(logic [7:0] addr, logic [7:0] sub, int fill, bit bad_sum);
      logic [7:0] s;
      logic [7:0] b;
      s = addr;
      put_word({1'b1, addr});
      put_word({1'b0, sub});
      s = s + sub;
      for (int i = 0; i < fill; i++) begin
         do b = 8'($urandom); while (b == s);
         put_word({1'b0, b});
         s = s + b;
      end
      if (bad_sum) put_word({1'b0, s ^ 8'h5a});
      else put_word({1'b0, s});
      frames++;
   endtask

   task automatic cmd(logic [2:0] c, logic [7:0] sub);
      put_frame(READER_ADDR | 8'(c), sub, 0, 1'b0);
   endtask

   task automatic write_csr(logic [1:0] idx, logic [19:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      csr_writes++;
   endtask

   task automatic drain();
      stop_push();
      while (words_due != 0) @(posedge clock);
      repeat (16) @(posedge clock);
   endtask

   task automatic configure(logic [15:0] f, logic [19:0] il, logic [19:0] vl);
      drain();
      write_csr(CSR_FUNDS, {4'd0, f});
      write_csr(CSR_IDLE, il);
      write_csr(CSR_VEND, vl);
      @(posedge clock);
   endtask

   task automatic random_traffic(int n);
      int stop_at;
      int r;
      logic [2:0] c;
      logic [7:0] sub;
      stop_at = items + n;
      while (items < stop_at) begin
         r = $urandom_range(0, 99);
         if (r < 50) begin
            c = 3'($urandom_range(0, 4));
            if ($urandom_range(0, 9) == 0) c = CMD_EXPANSION;
            sub = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 4));
            if (c == CMD_POLL || $urandom_range(0, 2) == 0) cmd(CMD_POLL, sub);
            else cmd(c, sub);
         end else if (r < 62) put_ticks($urandom_range(1, 10));
         else if (r < 78) put_event(3'($urandom), 16'($urandom));
         else if (r < 82) put_frame(READER_ADDR | 8'($urandom_range(0, 7)),
                                    8'($urandom_range(0, 4)), $urandom_range(30, 45), 1'b0);
         else if (r < 86) put_frame(8'($urandom), 8'($urandom), $urandom_range(0, 3), 1'b0);
         else if (r < 90) put_frame(READER_ADDR | 8'($urandom_range(0, 7)),
                                    8'($urandom_range(0, 4)), 1, 1'b1);
         else if (r < 96) put_word(9'($urandom));
         else begin
            req_data_noise();
         end
      end
   endtask

   task automatic req_data_noise();
      req_type it;
      it = 30'($urandom);
      it.operation = 2'd3;
      put_item(it);
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: every command, event and corner
      configure(16'hffff, 20'd3, 20'd5);
      cmd(CMD_RESET, 8'h00);
      cmd(CMD_POLL, 8'h00);
      cmd(CMD_SETUP, 8'h00);
      cmd(CMD_READER, 8'h01);
      put_event(HEV_BEGIN, 16'h0000);
      put_event(HEV_APPROVE, 16'hffff);
      put_event(HEV_OUTSEQ, 16'h0000);
      cmd(CMD_POLL, 8'h00);
      cmd(CMD_POLL, 8'h00);
      put_event(HEV_APPROVE, 16'h8001);
      cmd(CMD_POLL, 8'h00);
      cmd(CMD_VEND, 8'h00);
      put_ticks(7);
      cmd(CMD_POLL, 8'h00);
      cmd(CMD_POLL, 8'h00);
      cmd(CMD_VEND, 8'h02);
      put_event(HEV_CANCEL, 16'h0000);
      put_event(HEV_END, 16'h0000);
      put_event(HEV_DENY, 16'h0000);
      put_event(3'd7, 16'hffff);
      cmd(CMD_READER, 8'h02);
      cmd(CMD_EXPANSION, 8'h00);
      req_data_noise();
      put_word(9'h0ff);
      put_frame(READER_ADDR | 8'(CMD_POLL), 8'h00, 40, 1'b0);

      random_traffic(130);
      // hold off until all replies are back
      stop_push();
      while (words_due != 0) @(posedge clock);
      random_traffic(20);

      configure(16'h0000, 20'd0, 20'd0);
      random_traffic(120);
      configure(16'h1234, 20'd600000, 20'd600000);
      calm = 1'b1;
      random_traffic(110);
      calm = 1'b0;
      configure(16'($urandom), 20'($urandom_range(2, 30)), 20'($urandom_range(2, 30)));
      random_traffic(120);

      drain();
      $display("%0d items in %0d frames plus ticks and host events, %0d register writes",
               items, frames, csr_writes);
      $display("%0d reply words compared", words_seen);
      if (errors == 0 && words_due == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
